// File: rtl/hsf_pkg.sv
// ----------------------------------------------------------------------------
// hsf_pkg
// shared types, register codes and the seven-segment table for the hex
// switch filter and display block
// ----------------------------------------------------------------------------
package hsf_pkg;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  // register indexes on the configuration channel
  localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_INTERVAL  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DIRECTION_SELECT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LED_MODE         = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BRIGHTNESS       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_OFF_DELAY        = 3'd4;

  // display modes
  localparam logic [7:0] MODE_DARK = 8'h00;
  localparam logic [7:0] MODE_LIT  = 8'hFE;

  // reset values
  localparam logic [9:0]  RST_SAMPLE_INTERVAL  = 10'd10;
  localparam logic        RST_DIRECTION_SELECT = 1'b0;
  localparam logic [7:0]  RST_LED_MODE         = 8'hFF;
  localparam logic [7:0]  RST_BRIGHTNESS       = 8'hFF;
  localparam logic [31:0] RST_OFF_DELAY        = 32'd5000;
  localparam logic [7:0]  RST_LAST_SEEN        = 8'hFF;

  localparam logic [9:0]  SAMPLE_ELAPSED_MAX = 10'd1023;
  localparam logic [32:0] LIT_ELAPSED_MAX    = 33'h1_0000_0000;

  typedef struct packed {
    logic [9:0]  sample_interval;
    logic        direction_select;
    logic [7:0]  led_mode;
    logic [7:0]  brightness;
    logic [31:0] off_delay;
  } cfg_t;

  typedef struct packed {
    logic [3:0] position_value;
    logic [6:0] segment_mask;
    logic [7:0] segment_duty;
  } res_t;

  // segment A in bit 6 down to G in bit 0
  function automatic logic [6:0] seg_decode(input logic [3:0] v);
    logic [6:0] s;
    unique case (v)
      4'h0: s = 7'h7E;
      4'h1: s = 7'h30;
      4'h2: s = 7'h6D;
      4'h3: s = 7'h79;
      4'h4: s = 7'h33;
      4'h5: s = 7'h5B;
      4'h6: s = 7'h5F;
      4'h7: s = 7'h70;
      4'h8: s = 7'h7F;
      4'h9: s = 7'h7B;
      4'hA: s = 7'h77;
      4'hB: s = 7'h1F;
      4'hC: s = 7'h4E;
      4'hD: s = 7'h3D;
      4'hE: s = 7'h4F;
      4'hF: s = 7'h47;
      default: s = 7'h00;
    endcase
    return s;
  endfunction

endpackage

// File: rtl/hsf_ifs.sv
// ----------------------------------------------------------------------------
// hsf channel interfaces
// switch tick input, display result output and register write channels
// ----------------------------------------------------------------------------
interface hsf_in_if;
  logic       valid;
  logic       ready;
  logic [3:0] switch_pins;
  modport source (output valid, output switch_pins, input ready);
  modport sink   (input valid, input switch_pins, output ready);
endinterface

interface hsf_out_if;
  logic       valid;
  logic       ready;
  logic [3:0] position_value;
  logic [6:0] segment_mask;
  logic [7:0] segment_duty;
  modport source (output valid, output position_value, output segment_mask,
                  output segment_duty, input ready);
  modport sink   (input valid, input position_value, input segment_mask,
                  input segment_duty, output ready);
endinterface

interface hsf_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [hsf_pkg::CFG_IDX_W-1:0]  index;
  logic [hsf_pkg::CFG_DATA_W-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// File: rtl/hsf_sampler.sv
// ----------------------------------------------------------------------------
// hsf_sampler
// interval sampling and window agreement filter; the window is tracked as
// the last written sample and how many trailing writes matched it
// ----------------------------------------------------------------------------
module hsf_sampler #(
  parameter int WINDOW_DEPTH = 8
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       step,
  input  logic [3:0] switch_pins,
  input  logic [9:0] sample_interval,
  output logic [3:0] stable_next
);
  import hsf_pkg::*;

  localparam int RUN_W = $clog2(WINDOW_DEPTH + 1);
  localparam logic [RUN_W-1:0] RUN_FULL = RUN_W'(WINDOW_DEPTH);
  localparam logic [RUN_W-1:0] RUN_ONE  = RUN_W'(1);

  logic             primed;
  logic [9:0]       sample_elapsed;
  logic [RUN_W-1:0] run;
  logic [3:0]       last_pos;
  logic [3:0]       stable_position;

  logic [9:0]       sample_elapsed_next;
  logic [9:0]       elapsed_inc;
  logic [RUN_W-1:0] run_next;
  logic [3:0]       last_pos_next;
  logic [3:0]       pos;

  assign pos = ~switch_pins;

  always_comb begin
    elapsed_inc         = (sample_elapsed == SAMPLE_ELAPSED_MAX) ? sample_elapsed
                                                                 : sample_elapsed + 10'd1;
    sample_elapsed_next = sample_elapsed;
    run_next            = run;
    last_pos_next       = last_pos;
    if (!primed) begin
      // first tick fills the whole window
      sample_elapsed_next = '0;
      run_next            = RUN_FULL;
      last_pos_next       = pos;
    end else if (elapsed_inc >= sample_interval) begin
      sample_elapsed_next = '0;
      last_pos_next       = pos;
      if (pos != last_pos) begin
        run_next = RUN_ONE;
      end else if (run != RUN_FULL) begin
        run_next = run + RUN_ONE;
      end
    end else begin
      sample_elapsed_next = elapsed_inc;
    end
    stable_next = (run_next == RUN_FULL) ? last_pos_next : stable_position;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      primed          <= 1'b0;
      sample_elapsed  <= '0;
      run             <= '0;
      last_pos        <= '0;
      stable_position <= '0;
    end else if (step) begin
      primed          <= 1'b1;
      sample_elapsed  <= sample_elapsed_next;
      run             <= run_next;
      last_pos        <= last_pos_next;
      stable_position <= stable_next;
    end
  end

endmodule

// File: rtl/hsf_display.sv
// ----------------------------------------------------------------------------
// hsf_display
// direction mapping, change detection, lit timeout and segment decode
// ----------------------------------------------------------------------------
module hsf_display (
  input  logic          clk,
  input  logic          rst,
  input  logic          step,
  input  logic [3:0]    stable_pos,
  input  hsf_pkg::cfg_t cfg,
  output hsf_pkg::res_t res
);
  import hsf_pkg::*;

  logic [7:0]  last_value_seen;
  logic [7:0]  last_mode_seen;
  logic [7:0]  last_brightness_seen;
  logic        lit_flag;
  logic [32:0] lit_elapsed;

  logic        lit_flag_next;
  logic [32:0] lit_elapsed_next;
  logic [3:0]  shown;
  logic        changed;
  logic        lit;

  always_comb begin
    shown   = cfg.direction_select ? stable_pos : 4'd0 - stable_pos;
    changed = (last_value_seen != {4'd0, shown}) ||
              (last_mode_seen != cfg.led_mode) ||
              (last_brightness_seen != cfg.brightness);
    lit_flag_next    = lit_flag;
    lit_elapsed_next = lit_elapsed;
    priority if (cfg.led_mode == MODE_DARK) begin
      lit_flag_next = 1'b0;
      lit           = 1'b0;
    end else if (cfg.led_mode == MODE_LIT) begin
      lit_flag_next = 1'b0;
      lit           = 1'b1;
    end else begin
      if (changed) begin
        lit_flag_next    = 1'b1;
        lit_elapsed_next = '0;
      end else if (lit_flag) begin
        if (lit_elapsed != LIT_ELAPSED_MAX) begin
          lit_elapsed_next = lit_elapsed + 33'd1;
        end
        if (lit_elapsed_next > {1'b0, cfg.off_delay}) begin
          lit_flag_next = 1'b0;
        end
      end
      lit = lit_flag_next;
    end
    res.position_value = shown;
    res.segment_mask   = lit ? seg_decode(shown) : 7'd0;
    res.segment_duty   = lit ? cfg.brightness : 8'd0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_value_seen      <= RST_LAST_SEEN;
      last_mode_seen       <= RST_LAST_SEEN;
      last_brightness_seen <= RST_LAST_SEEN;
      lit_flag             <= 1'b0;
      lit_elapsed          <= '0;
    end else if (step) begin
      last_value_seen      <= {4'd0, shown};
      last_mode_seen       <= cfg.led_mode;
      last_brightness_seen <= cfg.brightness;
      lit_flag             <= lit_flag_next;
      lit_elapsed          <= lit_elapsed_next;
    end
  end

endmodule

// File: rtl/hex_switch_filter_segment_display.sv
// path: a tick transfer loads the input stage, and its result is registered
//   in the result register once that register is free, then shows on disp_out
// throughput: one tick per cycle unless disp_out holds off; input stage and result
//   register form a two-stage pipe; a waiting result still lets one tick in
// reset: synchronous active-high rst clears both stages, filter and display
//   state and loads the register defaults; cfg writes are taken every cycle
// ----------------------------------------------------------------------------
// hex_switch_filter_segment_display
// debounces a 16-position active-low hex switch over a sample window and
// drives a seven-segment digit with brightness and an off timeout
// ----------------------------------------------------------------------------
module hex_switch_filter_segment_display #(
  parameter int WINDOW_DEPTH = 8
) (
  input  logic       clk,
  input  logic       rst,
  hsf_in_if.sink     sw_in,
  hsf_out_if.source  disp_out,
  hsf_cfg_if.sink    cfg
);
  import hsf_pkg::*;

  // configuration registers
  cfg_t cfg_regs;

  // input stage: the raw pins of one tick
  logic       s1_valid;
  logic [3:0] s1_pins;

  // result register
  logic res_valid;
  res_t res;
  res_t res_next;

  logic       advance;   // result register can take a new value
  logic       step;      // stage 1 tick is processed and state commits
  logic [3:0] stable_next;

  // register writes never stall
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_regs.sample_interval  <= RST_SAMPLE_INTERVAL;
      cfg_regs.direction_select <= RST_DIRECTION_SELECT;
      cfg_regs.led_mode         <= RST_LED_MODE;
      cfg_regs.brightness       <= RST_BRIGHTNESS;
      cfg_regs.off_delay        <= RST_OFF_DELAY;
    end else if (cfg.valid) begin
      // unknown indexes are dropped
      unique case (cfg.index)
        REG_SAMPLE_INTERVAL:  cfg_regs.sample_interval  <= cfg.data[9:0];
        REG_DIRECTION_SELECT: cfg_regs.direction_select <= cfg.data[0];
        REG_LED_MODE:         cfg_regs.led_mode         <= cfg.data[7:0];
        REG_BRIGHTNESS:       cfg_regs.brightness       <= cfg.data[7:0];
        REG_OFF_DELAY:        cfg_regs.off_delay        <= cfg.data;
        default: ;
      endcase
    end
  end

  // pipe control: result register frees up when empty or being taken
  assign advance      = !res_valid || disp_out.ready;
  assign step         = s1_valid && advance;
  assign sw_in.ready  = !s1_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (sw_in.valid && sw_in.ready) begin
      s1_valid <= 1'b1;
    end else if (step) begin
      s1_valid <= 1'b0;
    end
  end

  // payload needs no reset
  always_ff @(posedge clk) begin
    if (sw_in.valid && sw_in.ready) begin
      s1_pins <= sw_in.switch_pins;
    end
  end

  // window filter, state advances only when a tick moves into the result
  hsf_sampler #(
    .WINDOW_DEPTH (WINDOW_DEPTH)
  ) u_sampler (
    .clk             (clk),
    .rst             (rst),
    .step            (step),
    .switch_pins     (s1_pins),
    .sample_interval (cfg_regs.sample_interval),
    .stable_next     (stable_next)
  );

  // direction, change detect, timeout and digit decode
  hsf_display u_display (
    .clk        (clk),
    .rst        (rst),
    .step       (step),
    .stable_pos (stable_next),
    .cfg        (cfg_regs),
    .res        (res_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (advance) begin
      res_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      res <= res_next;
    end
  end

  assign disp_out.valid          = res_valid;
  assign disp_out.position_value = res.position_value;
  assign disp_out.segment_mask   = res.segment_mask;
  assign disp_out.segment_duty   = res.segment_duty;

endmodule

// File: rtl/hsf_checker.sv
// ----------------------------------------------------------------------------
// hsf_checker
// port-level checks on the hex switch filter display block
// ----------------------------------------------------------------------------
module hsf_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [6:0] segment_mask,
  input logic [7:0] segment_duty
);

  // a waiting result stays offered until its transfer
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped before transfer");

  // every tick transfer must be followed by an offered result
  a_in_to_out: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |-> ##2 out_valid)
    else $error("no result after tick transfer");

  // nonzero duty only on a lit digit, and every digit lights some segment
  a_duty_mask: assert property (@(posedge clk) disable iff (rst)
    out_valid && segment_duty != 8'd0 |-> segment_mask != 7'd0)
    else $error("duty driven with all segments dark");

  // nothing offered right after reset
  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("result offered after reset");

endmodule

bind hex_switch_filter_segment_display hsf_checker u_hsf_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (sw_in.valid),
  .in_ready     (sw_in.ready),
  .out_valid    (disp_out.valid),
  .out_ready    (disp_out.ready),
  .segment_mask (disp_out.segment_mask),
  .segment_duty (disp_out.segment_duty)
);

// File: tb/sv/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the hex switch filter and segment display: ticks
// of raw switch pins go in, every display transfer is compared field by
// field with an in-bench model of the window filter, direction map, decoder
// and lit timeout
// ----------------------------------------------------------------------------
module tb_top;
  import hsf_pkg::*;

  localparam int DEPTH       = 8;
  localparam int QUIET_LIMIT = 4000;  // cycles with no transfer of any kind
  localparam int SHOW_MAX    = 10;
  localparam int PHASES      = 8;
  localparam int PHASE_TICKS = 190;
  localparam int PLAN_ROWS   = 29;

  // seven-segment patterns, digit 0 in the low bits, A in bit 6 of each
  localparam logic [16*7-1:0] SEG_ROM = {
    7'h47, 7'h4F, 7'h3D, 7'h4E, 7'h1F, 7'h77, 7'h7B, 7'h7F,
    7'h70, 7'h5F, 7'h5B, 7'h33, 7'h79, 7'h6D, 7'h30, 7'h7E
  };

  localparam res_t NO_RES = '0;

  // one row of the directed plan: a register write or a tick, the latter
  // with an optional hand-typed display value
  typedef struct packed {
    bit          is_reg;
    logic [2:0]  idx;
    logic [31:0] data;
    logic [3:0]  pins;
    bit          pinned;
    res_t        want;
  } step_t;

  // per-tick note from the stimulus side: use the typed value or the model
  typedef struct packed {
    bit   on;
    res_t r;
  } pin_t;

  logic clk = 1'b0;
  logic rst;

  hsf_in_if  sw_if ();
  hsf_out_if disp_if ();
  hsf_cfg_if cfg_if ();

  hex_switch_filter_segment_display #(
    .WINDOW_DEPTH(DEPTH)
  ) dut (
    .clk     (clk),
    .rst     (rst),
    .sw_in   (sw_if),
    .disp_out(disp_if),
    .cfg     (cfg_if)
  );

  always #1 clk = ~clk;

  // ---------------------------------------------------------------------------
  // filter and display model state, mirrors the block from reset onward
  // ---------------------------------------------------------------------------
  cfg_t        shadow = '{RST_SAMPLE_INTERVAL, RST_DIRECTION_SELECT, RST_LED_MODE,
                          RST_BRIGHTNESS, RST_OFF_DELAY};
  logic [3:0]  win [DEPTH];
  int          wr_slot     = 0;
  bit          primed      = 1'b0;
  logic [3:0]  stable      = 4'h0;
  logic [9:0]  smp_elapsed = '0;
  logic [3:0]  shown       = 4'h0;
  logic [7:0]  seen_val    = RST_LAST_SEEN;
  logic [7:0]  seen_mode   = RST_LAST_SEEN;
  logic [7:0]  seen_bright = RST_LAST_SEEN;
  bit          lit_on      = 1'b0;
  logic [32:0] lit_count   = '0;

  // expected display transfers, oldest first, and the per-tick typed notes
  res_t pending_disp [$];
  pin_t typed_disp [$];

  int   errs      = 0;
  int   quiet     = 0;
  int   gap_pct   = 0;   // chance of the sender idling before a tick
  int   stall_pct = 0;   // chance of the receiver holding off a cycle
  bit   ticked    = 1'b0;
  res_t predicted;
  res_t want;
  pin_t pinned;

  // ---------------------------------------------------------------------------
  // one millisecond tick through the model: sample, vote, map, decode, light
  // ---------------------------------------------------------------------------
  function automatic res_t filter_tick(input logic [3:0] pins);
    logic [3:0] pos;
    bit         agree;
    bit         fresh;
    bit         lit;
    res_t       r;
    pos = ~pins;
    if (!primed) begin
      // first tick after reset loads the whole window
      for (int i = 0; i < DEPTH; i++) win[i] = pos;
      stable      = pos;
      wr_slot     = 0;
      smp_elapsed = '0;
      primed      = 1'b1;
    end else begin
      if (smp_elapsed < SAMPLE_ELAPSED_MAX) smp_elapsed = smp_elapsed + 1'b1;
      if (smp_elapsed >= shadow.sample_interval) begin
        win[wr_slot] = pos;
        wr_slot      = (wr_slot + 1) % DEPTH;
        smp_elapsed  = '0;
      end
    end

    // window vote: only a unanimous window moves the stable position
    agree = 1'b1;
    for (int i = 1; i < DEPTH; i++) if (win[i] != win[0]) agree = 1'b0;
    if (agree) stable = win[0];

    // reversed direction shows 16-k, wrapping 0 onto itself
    shown = shadow.direction_select ? stable : 4'h0 - stable;

    fresh = (seen_val != {4'h0, shown}) || (seen_mode != shadow.led_mode) ||
            (seen_bright != shadow.brightness);
    seen_val    = {4'h0, shown};
    seen_mode   = shadow.led_mode;
    seen_bright = shadow.brightness;

    if (shadow.led_mode == MODE_DARK) begin
      lit_on = 1'b0;
      lit    = 1'b0;
    end else if (shadow.led_mode == MODE_LIT) begin
      lit_on = 1'b0;
      lit    = 1'b1;
    end else begin
      // change-lit mode: relight on any change, go dark past the off delay
      if (fresh) begin
        lit_on    = 1'b1;
        lit_count = '0;
      end else if (lit_on) begin
        if (lit_count < LIT_ELAPSED_MAX) lit_count = lit_count + 1'b1;
        if (lit_count > {1'b0, shadow.off_delay}) lit_on = 1'b0;
      end
      lit = lit_on;
    end

    r.position_value = shown;
    r.segment_mask   = lit ? SEG_ROM[int'(shown)*7 +: 7] : 7'h00;
    r.segment_duty   = lit ? shadow.brightness : 8'h00;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // directed plan: reset value, window fill at interval zero, every display
  // mode, masked register data, timeout with zero off delay
  // ---------------------------------------------------------------------------
  step_t plan [PLAN_ROWS] = '{
    // first tick primes the window with position 0, reversed stays 0
    '{1'b0, 3'd0, 32'd0, 4'hF, 1'b1, '{4'h0, 7'h7E, 8'hFF}},
    '{1'b0, 3'd0, 32'd0, 4'h0, 1'b1, '{4'h0, 7'h7E, 8'hFF}},
    '{1'b1, REG_SAMPLE_INTERVAL, 32'd0, 4'h0, 1'b0, NO_RES},
    '{1'b1, REG_DIRECTION_SELECT, 32'hFFFF_FFFF, 4'h0, 1'b0, NO_RES},
    // interval zero: eight ticks refill the window with position F
    '{1'b0, 3'd0, 32'd0, 4'h0, 1'b0, NO_RES},
    '{1'b0, 3'd0, 32'd0, 4'h0, 1'b0, NO_RES},
    '{1'b0, 3'd0, 32'd0, 4'h0, 1'b0, NO_RES},
    '{1'b0, 3'd0, 32'd0, 4'h0, 1'b0, NO_RES},
    '{1'b0, 3'd0, 32'd0, 4'h0, 1'b0, NO_RES},
    '{1'b0, 3'd0, 32'd0, 4'h0, 1'b0, NO_RES},
    '{1'b0, 3'd0, 32'd0, 4'h0, 1'b0, NO_RES},
    '{1'b0, 3'd0, 32'd0, 4'h0, 1'b1, '{4'hF, 7'h47, 8'hFF}},
    '{1'b1, REG_LED_MODE, {24'h0, MODE_DARK}, 4'h0, 1'b0, NO_RES},
    '{1'b0, 3'd0, 32'd0, 4'h0, 1'b1, '{4'hF, 7'h00, 8'h00}},
    '{1'b1, REG_LED_MODE, {24'h0, MODE_LIT}, 4'h0, 1'b0, NO_RES},
    '{1'b1, REG_BRIGHTNESS, 32'd0, 4'h0, 1'b0, NO_RES},
    '{1'b0, 3'd0, 32'd0, 4'h0, 1'b1, '{4'hF, 7'h47, 8'h00}},
    // change-lit with zero off delay: lit for one tick, dark on the next
    '{1'b1, REG_LED_MODE, 32'd1, 4'h0, 1'b0, NO_RES},
    '{1'b1, REG_OFF_DELAY, 32'd0, 4'h0, 1'b0, NO_RES},
    '{1'b1, REG_DIRECTION_SELECT, 32'hFFFF_FFFE, 4'h0, 1'b0, NO_RES},
    '{1'b0, 3'd0, 32'd0, 4'h0, 1'b1, '{4'h1, 7'h30, 8'h00}},
    '{1'b0, 3'd0, 32'd0, 4'h0, 1'b1, '{4'h1, 7'h00, 8'h00}},
    '{1'b0, 3'd0, 32'd0, 4'hF, 1'b0, NO_RES},
    '{1'b1, REG_OFF_DELAY, 32'hFFFF_FFFF, 4'h0, 1'b0, NO_RES},
    '{1'b1, REG_BRIGHTNESS, 32'h5A5A_5AAA, 4'h0, 1'b0, NO_RES},
    '{1'b1, REG_SAMPLE_INTERVAL, 32'hFFFF_FFFF, 4'h0, 1'b0, NO_RES},
    '{1'b0, 3'd0, 32'd0, 4'h5, 1'b0, NO_RES},
    '{1'b0, 3'd0, 32'd0, 4'hA, 1'b0, NO_RES},
    '{1'b0, 3'd0, 32'd0, 4'h0, 1'b0, NO_RES}
  };

  // ---------------------------------------------------------------------------
  // drivers
  // ---------------------------------------------------------------------------

  // one tick transfer, with a random idle stretch in front of it
  task automatic send_tick(input logic [3:0] pins, input bit use_typed, input res_t typed);
    typed_disp.push_back({use_typed, typed});
    cfg_if.valid <= 1'b0;
    if (gap_pct != 0 && $urandom_range(99) < gap_pct) begin
      sw_if.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < gap_pct);
    end
    sw_if.valid       <= 1'b1;
    sw_if.switch_pins <= pins;
    do @(posedge clk); while (!sw_if.ready);
    ticked = 1'b1;
  endtask

  // register write, valid left high so back-to-back writes need no gap
  task automatic reg_write(input logic [2:0] idx, input logic [31:0] data);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= data;
    do @(posedge clk); while (!cfg_if.ready);
  endtask

  // stop sending and wait until every expected display transfer is back
  task automatic settle();
    sw_if.valid  <= 1'b0;
    cfg_if.valid <= 1'b0;
    do @(negedge clk); while (pending_disp.size() != 0);
    @(posedge clk);
    ticked = 1'b0;
  endtask

  // receiver: ready drawn fresh every cycle
  initial begin
    disp_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      disp_if.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: model on tick transfers, compare on display transfers, watchdog
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_if.valid && cfg_if.ready) begin
        case (cfg_if.index)
          REG_SAMPLE_INTERVAL:  shadow.sample_interval  = cfg_if.data[9:0];
          REG_DIRECTION_SELECT: shadow.direction_select = cfg_if.data[0];
          REG_LED_MODE:         shadow.led_mode         = cfg_if.data[7:0];
          REG_BRIGHTNESS:       shadow.brightness       = cfg_if.data[7:0];
          REG_OFF_DELAY:        shadow.off_delay        = cfg_if.data;
          default: ;  // unused indexes are dropped
        endcase
      end

      if (sw_if.valid && sw_if.ready) begin
        pinned    = typed_disp.pop_front();
        predicted = filter_tick(sw_if.switch_pins);
        pending_disp.push_back(pinned.on ? pinned.r : predicted);
      end

      if (disp_if.valid && disp_if.ready) begin
        if (pending_disp.size() == 0) begin
          errs++;
          if (errs <= SHOW_MAX)
            $display("tb_top: display transfer with nothing pending: pos %h seg %h duty %h",
                     disp_if.position_value, disp_if.segment_mask, disp_if.segment_duty);
        end else begin
          want = pending_disp.pop_front();
          if (disp_if.position_value !== want.position_value ||
              disp_if.segment_mask !== want.segment_mask ||
              disp_if.segment_duty !== want.segment_duty) begin
            errs++;
            if (errs <= SHOW_MAX)
              $display("tb_top: mismatch want pos %h seg %h duty %h, got pos %h seg %h duty %h",
                       want.position_value, want.segment_mask, want.segment_duty,
                       disp_if.position_value, disp_if.segment_mask, disp_if.segment_duty);
          end
        end
      end

      // watchdog on cycles where nothing moves on any channel
      if ((sw_if.valid && sw_if.ready) || (disp_if.valid && disp_if.ready) ||
          (cfg_if.valid && cfg_if.ready))
        quiet = 0;
      else
        quiet++;
      if (quiet >= QUIET_LIMIT) begin
        $display("tb_top: errors");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------
  initial begin
    int         sent;
    int         len;
    int         kind;
    int         hold_max;
    int         gap_base;
    int         stall_base;
    bit         calm;
    bit         retuned;
    logic [3:0] pins;
    logic [3:0] alt;
    logic [9:0] interval;
    logic [7:0] mode;

    rst               <= 1'b1;
    sw_if.valid       <= 1'b0;
    sw_if.switch_pins <= 4'h0;
    cfg_if.valid      <= 1'b0;
    cfg_if.index      <= 3'd0;
    cfg_if.data       <= 32'd0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // directed plan, no idling
    for (int k = 0; k < PLAN_ROWS; k++) begin
      if (plan[k].is_reg) begin
        if (ticked) settle();
        reg_write(plan[k].idx, plan[k].data);
      end else begin
        send_tick(plan[k].pins, plan[k].pinned, plan[k].want);
      end
    end

    // random phases, each with its own register setting and idle pattern
    for (int p = 0; p < PHASES; p++) begin
      settle();

      // interval extremes: zero, one and the saturating 1023
      case (p)
        2:       interval = 10'd0;
        5:       interval = 10'd1023;
        6:       interval = 10'd1;
        default: interval = 10'($urandom_range(4, 1));
      endcase
      case (p)
        1:       mode = MODE_LIT;
        3:       mode = MODE_DARK;
        4:       mode = 8'h01;
        7:       mode = 8'hFF;
        default: mode = 8'($urandom_range(253, 1));
      endcase
      // upper data bits are random to exercise the width masking
      reg_write(REG_SAMPLE_INTERVAL, {22'($urandom()), interval});
      reg_write(REG_DIRECTION_SELECT, {31'($urandom()), p[0]});
      reg_write(REG_LED_MODE, {24'($urandom()), mode});
      reg_write(REG_BRIGHTNESS, {24'($urandom()),
                                 p == 0 ? 8'h00 : p == 1 ? 8'hFF : 8'($urandom())});
      reg_write(REG_OFF_DELAY, p == 2 ? 32'd0 : p == 6 ? 32'hFFFF_FFFF :
                                32'($urandom_range(40)));
      // writes to indexes past the last register must change nothing
      for (int k = REG_OFF_DELAY + 1; k < 8; k++) reg_write(3'(k), $urandom());

      case (p % 4)
        0:       begin gap_base = 0;  stall_base = 0;  end
        1:       begin gap_base = 57; stall_base = 0;  end
        2:       begin gap_base = 0;  stall_base = 57; end
        default: begin gap_base = 33; stall_base = 33; end
      endcase

      // long enough holds for the whole window to agree at intervals up to 6; above that, holds cap at 60
      hold_max = (interval > 10'd6) ? 60 : 8 * (int'(interval) + 1) + 12;

      sent    = 0;
      retuned = 1'b0;
      while (sent < PHASE_TICKS) begin
        // halfway: sender holds until the display caught up, then retunes
        if (!retuned && sent >= PHASE_TICKS / 2) begin
          settle();
          if ($urandom_range(1)) reg_write(REG_BRIGHTNESS, $urandom());
          else reg_write(REG_LED_MODE, $urandom());
          retuned = 1'b1;
        end

        // occasional stretches with no idling at all
        calm      = ($urandom_range(4) == 0);
        gap_pct   = calm ? 0 : gap_base;
        stall_pct = calm ? 0 : stall_base;

        kind = $urandom_range(9);
        pins = 4'($urandom_range(15));
        alt  = 4'($urandom_range(15));
        len  = (kind < 7) ? $urandom_range(hold_max, 1) : $urandom_range(6, 1);
        for (int j = 0; j < len && sent < PHASE_TICKS; j++) begin
          if (kind == 7) send_tick(4'($urandom_range(15)), 1'b0, NO_RES);  // noise
          else if (kind == 8) send_tick(j[0] ? alt : pins, 1'b0, NO_RES);  // chatter
          else send_tick(pins, 1'b0, NO_RES);                              // steady
          sent++;
        end
      end
    end

    gap_pct   = 0;
    stall_pct = 0;
    settle();
    // anything stray shows up well inside this pause
    repeat (8) @(posedge clk);
    if (errs == 0 && pending_disp.size() == 0)
      $display("tb_top: clean");
    else
      $display("tb_top: errors");
    $finish;
  end

endmodule
